### design/lcd_text_escape_parser_unit_macros.svh
// Assertion macros used by the parser block.
`ifndef LCD_TEXT_ESCAPE_PARSER_UNIT_MACROS_SVH
`define LCD_TEXT_ESCAPE_PARSER_UNIT_MACROS_SVH

// Check that cond holds on the same edge as ante.
`define LTEP_ASSERT_NOW(label, clk, rst_n, ante, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cond)) \
        else $error(msg);

// Check that cond holds on the edge after ante.
`define LTEP_ASSERT_NEXT(label, clk, rst_n, ante, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cond)) \
        else $error(msg);

`endif

### design/ltep_pkg.sv
package ltep_pkg;

    localparam int CHAR_W  = 8;
    localparam int X_W     = 16;
    localparam int Y_W     = 8;
    localparam int COLOR_W = 16;
    localparam int HEX_W   = 24;
    localparam int CNT_W   = 3;
    localparam int PHASE_W = 2;

    localparam logic [PHASE_W-1:0] PH_TEXT  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_SLASH = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HEX   = 2'd2;

    localparam logic KIND_DRAW  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [COLOR_W-1:0] COL_WHITE   = 16'hFFFF;
    localparam logic [COLOR_W-1:0] COL_RED     = 16'hF800;
    localparam logic [COLOR_W-1:0] COL_GREEN   = 16'h07E0;
    localparam logic [COLOR_W-1:0] COL_BLUE    = 16'h001F;
    localparam logic [COLOR_W-1:0] COL_YELLOW  = 16'hFFE0;
    localparam logic [COLOR_W-1:0] COL_CYAN    = 16'h07FF;
    localparam logic [COLOR_W-1:0] COL_MAGENTA = 16'hF81F;

    localparam int SMALL_FONT_H = 12;
    localparam int LARGE_FONT_H = 16;
    localparam logic [X_W-1:0] ADV_SMALL = X_W'(SMALL_FONT_H / 2);
    localparam logic [X_W-1:0] ADV_LARGE = X_W'(LARGE_FONT_H / 2);

    localparam logic [CNT_W-1:0] HEX_DIGITS = 3'd6;

    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC    = 8'h43;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LC    = 8'h63;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LG    = 8'h67;
    localparam logic [CHAR_W-1:0] CH_LM    = 8'h6D;
    localparam logic [CHAR_W-1:0] CH_LR    = 8'h72;
    localparam logic [CHAR_W-1:0] CH_LW    = 8'h77;
    localparam logic [CHAR_W-1:0] CH_LY    = 8'h79;

    typedef struct packed {
        logic               kind;
        logic [CHAR_W-1:0]  glyph;
        logic [X_W-1:0]     x_pos;
        logic [Y_W-1:0]     y_pos;
        logic [COLOR_W-1:0] glyph_color;
        logic               large_font;
    } t_result;

    function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[CH_UA:CH_UF]}) begin
            v = 4'(c - CH_UA + 8'd10);
        end else if (c inside {[CH_LA:CH_LF]}) begin
            v = 4'(c - CH_LA + 8'd10);
        end else if (c inside {[CH_0:CH_9]}) begin
            v = c[3:0];
        end
        return v;
    endfunction

    function automatic logic [COLOR_W-1:0] rgb888_to_565(input logic [HEX_W-1:0] d);
        return {d[23:19], d[15:10], d[7:3]};
    endfunction

endpackage

### design/ltep_parser.sv
`include "lcd_text_escape_parser_unit_macros.svh"

module ltep_parser import ltep_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_eos,
    output logic              o_result_valid,
    output t_result           o_result
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CNT_W-1:0]   r_hex_count, n_hex_count;
    logic [HEX_W-1:0]   r_hex_accum, n_hex_accum;
    logic [X_W-1:0]     r_cursor_x, n_cursor_x;
    logic [Y_W-1:0]     r_cursor_y, n_cursor_y;
    logic [COLOR_W-1:0] r_pen_color, n_pen_color;
    logic               r_font_large, n_font_large;

    logic [HEX_W-1:0]   hex_shift;
    logic [CNT_W-1:0]   hex_count_inc;

    always_comb begin
        n_phase       = r_phase;
        n_hex_count   = r_hex_count;
        n_hex_accum   = r_hex_accum;
        n_cursor_x    = r_cursor_x;
        n_cursor_y    = r_cursor_y;
        n_pen_color   = r_pen_color;
        n_font_large  = r_font_large;
        hex_shift     = {r_hex_accum[HEX_W-5:0], hex_value(i_char)};
        hex_count_inc = r_hex_count + 3'd1;

        o_result_valid         = 1'b0;
        o_result.kind          = KIND_DRAW;
        o_result.glyph         = i_char;
        o_result.x_pos         = r_cursor_x;
        o_result.y_pos         = r_cursor_y;
        o_result.glyph_color   = r_pen_color;
        o_result.large_font    = r_font_large;

        case (r_phase)
            PH_SLASH: begin
                n_phase = PH_TEXT;
                if (i_char inside {[CH_0:CH_9]}) begin
                    n_cursor_x = '0;
                    n_cursor_y = {i_char[3:0], 4'b0000};
                end else begin
                    case (i_char)
                        CH_SLASH: begin
                            o_result_valid = 1'b1;
                            n_cursor_x = r_cursor_x + (r_font_large ? ADV_LARGE : ADV_SMALL);
                        end
                        CH_LW: n_pen_color = COL_WHITE;
                        CH_LR: n_pen_color = COL_RED;
                        CH_LG: n_pen_color = COL_GREEN;
                        CH_LB: n_pen_color = COL_BLUE;
                        CH_LY: n_pen_color = COL_YELLOW;
                        CH_LC: n_pen_color = COL_CYAN;
                        CH_LM: n_pen_color = COL_MAGENTA;
                        CH_UA: n_font_large = 1'b1;
                        CH_LA: n_font_large = 1'b0;
                        CH_UC: begin
                            n_cursor_x   = '0;
                            n_cursor_y   = '0;
                            n_pen_color  = COL_WHITE;
                            n_font_large = 1'b0;
                            o_result_valid       = 1'b1;
                            o_result.kind        = KIND_CLEAR;
                            o_result.glyph       = '0;
                            o_result.x_pos       = '0;
                            o_result.y_pos       = '0;
                            o_result.glyph_color = '0;
                            o_result.large_font  = 1'b0;
                        end
                        CH_HASH: begin
                            n_phase     = PH_HEX;
                            n_hex_count = '0;
                            n_hex_accum = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            PH_HEX: begin
                n_hex_accum = hex_shift;
                n_hex_count = hex_count_inc;
                if (hex_count_inc >= HEX_DIGITS) begin
                    n_pen_color = rgb888_to_565(hex_shift);
                    n_phase     = PH_TEXT;
                    n_hex_count = '0;
                    n_hex_accum = '0;
                end
            end
            default: begin
                n_phase = PH_TEXT;
                if (i_char == CH_SLASH) begin
                    n_phase = PH_SLASH;
                end else begin
                    o_result_valid = 1'b1;
                    n_cursor_x = r_cursor_x + (r_font_large ? ADV_LARGE : ADV_SMALL);
                end
            end
        endcase

        // drop any pending escape at end of string
        if (i_eos) begin
            n_phase     = PH_TEXT;
            n_hex_count = '0;
            n_hex_accum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TEXT;
            r_hex_count  <= '0;
            r_hex_accum  <= '0;
            r_cursor_x   <= '0;
            r_cursor_y   <= '0;
            r_pen_color  <= COL_WHITE;
            r_font_large <= 1'b0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_hex_count  <= n_hex_count;
            r_hex_accum  <= n_hex_accum;
            r_cursor_x   <= n_cursor_x;
            r_cursor_y   <= n_cursor_y;
            r_pen_color  <= n_pen_color;
            r_font_large <= n_font_large;
        end
    end

    `LTEP_ASSERT_NOW(a_hex_count_range, i_clk, i_rst_n, 1'b1, r_hex_count < HEX_DIGITS, "hex count out of range")
    `LTEP_ASSERT_NOW(a_hex_idle_clear, i_clk, i_rst_n, r_phase != PH_HEX, (r_hex_count == '0) && (r_hex_accum == '0), "hex state not cleared")
    `LTEP_ASSERT_NEXT(a_eos_to_text, i_clk, i_rst_n, i_advance && i_eos, (r_phase == PH_TEXT) && (r_hex_count == '0), "escape pending after end of string")

endmodule

### design/ltep_out_reg.sv
module ltep_out_reg import ltep_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_valid,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### design/lcd_text_escape_parser_unit.sv
// Text character stream to LCD draw requests.
// Slave channel s_axis_*: one character per request, tlast marks the last
// character of a string. Master channel m_axis_*: zero or one draw or clear
// request per character, tuser is the kind (0 draw glyph, 1 clear screen).
// Escapes start with a slash: digit picks a line, w r g b y c m pick a
// palette color, A / a pick the 8x16 / 6x12 font, C clears, # takes six hex
// digits as RGB888, a second slash draws a slash.
// Path: a taken character goes into the input register, is decoded
// combinationally and its result is loaded into the result register, which
// drives m_axis; a held result can stall the load. Throughput: one
// character per cycle while m_axis_tready does not hold a result back.
// Characters that give no result still pass through the decode.
// Reset: cursor at 0,0, white pen, small font, no escape pending; both
// registers empty.
// Stall: while m_axis_tready is low and a result is held, the input
// register holds its character and s_axis_tready drops once it is full.
module lcd_text_escape_parser_unit import ltep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // glyph[7:0], x_pos[23:8], y_pos[31:24],
                                        // glyph_color[47:32], large_font[48], zero[55:49]
    output logic        m_axis_tuser    // kind
);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_eos;

    logic    advance;
    logic    can_load;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign advance       = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_eos  <= s_axis_tlast;
        end
    end

    ltep_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_char         (r_in_char),
        .i_eos          (r_in_eos),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    ltep_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_valid    (res_valid),
        .i_result   (res),
        .i_ready    (m_axis_tready),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .o_result   (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {7'b0, out_res.large_font, out_res.glyph_color,
                           out_res.y_pos, out_res.x_pos, out_res.glyph};

endmodule

### sim/lcd_text_escape_parser_unit_tb.sv
module lcd_text_escape_parser_unit_tb;
    import ltep_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int FONT_RUN    = 20;

    class draw_scoreboard;
        logic [1:0]  phase;
        logic [2:0]  hex_cnt;
        logic [23:0] hex_acc;
        logic [15:0] cur_x;
        logic [7:0]  cur_y;
        logic [15:0] pen;
        logic        big;
        t_result     expected_q[$];
        int          mismatches;
        int          draws_seen;
        int          clears_seen;

        function new();
            phase       = PH_TEXT;
            hex_cnt     = '0;
            hex_acc     = '0;
            cur_x       = '0;
            cur_y       = '0;
            pen         = COL_WHITE;
            big         = 1'b0;
            mismatches  = 0;
            draws_seen  = 0;
            clears_seen = 0;
        endfunction

        function void note_char(logic [7:0] c, logic eos);
            t_result    r;
            logic       draw_it;
            logic [3:0] nib;
            r       = '0;
            draw_it = 1'b0;
            if (phase == PH_SLASH) begin
                phase = PH_TEXT;
                if (c >= CH_0 && c <= CH_9) begin
                    cur_x = '0;
                    cur_y = 8'(16 * (c - CH_0));
                end else begin
                    case (c)
                        CH_SLASH: draw_it = 1'b1;
                        CH_LW: pen = COL_WHITE;
                        CH_LR: pen = COL_RED;
                        CH_LG: pen = COL_GREEN;
                        CH_LB: pen = COL_BLUE;
                        CH_LY: pen = COL_YELLOW;
                        CH_LC: pen = COL_CYAN;
                        CH_LM: pen = COL_MAGENTA;
                        CH_UA: big = 1'b1;
                        CH_LA: big = 1'b0;
                        CH_UC: begin
                            cur_x = '0;
                            cur_y = '0;
                            pen   = COL_WHITE;
                            big   = 1'b0;
                            r.kind = KIND_CLEAR;
                            expected_q.push_back(r);
                        end
                        CH_HASH: begin
                            phase   = PH_HEX;
                            hex_cnt = '0;
                            hex_acc = '0;
                        end
                        default: ;
                    endcase
                end
            end else if (phase == PH_HEX) begin
                if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
                    nib = c[3:0] + 4'd9;
                end else if (c >= CH_0 && c <= CH_9) begin
                    nib = c[3:0];
                end else begin
                    nib = 4'd0;
                end
                hex_acc = {hex_acc[19:0], nib};
                hex_cnt = hex_cnt + 3'd1;
                if (hex_cnt >= HEX_DIGITS) begin
                    pen     = {hex_acc[23:19], hex_acc[15:10], hex_acc[7:3]};
                    phase   = PH_TEXT;
                    hex_cnt = '0;
                    hex_acc = '0;
                end
            end else begin
                phase = PH_TEXT;
                if (c == CH_SLASH) begin
                    phase = PH_SLASH;
                end else begin
                    draw_it = 1'b1;
                end
            end
            if (draw_it) begin
                r.kind        = KIND_DRAW;
                r.glyph       = c;
                r.x_pos       = cur_x;
                r.y_pos       = cur_y;
                r.glyph_color = pen;
                r.large_font  = big;
                expected_q.push_back(r);
                cur_x = cur_x + (big ? ADV_LARGE : ADV_SMALL);
            end
            if (eos) begin
                phase   = PH_TEXT;
                hex_cnt = '0;
                hex_acc = '0;
            end
        endfunction

        function void check_request(logic [55:0] data, logic user);
            t_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected request, expected none got tuser %h tdata %h",
                         $time, user, data);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (user === KIND_CLEAR) clears_seen++;
            else draws_seen++;
            if (user !== e.kind) begin
                $display("%0t: kind expected %h got %h", $time, e.kind, user);
                mismatches++;
            end
            if (data[7:0] !== e.glyph) begin
                $display("%0t: glyph expected %h got %h", $time, e.glyph, data[7:0]);
                mismatches++;
            end
            if (data[23:8] !== e.x_pos) begin
                $display("%0t: x_pos expected %h got %h", $time, e.x_pos, data[23:8]);
                mismatches++;
            end
            if (data[31:24] !== e.y_pos) begin
                $display("%0t: y_pos expected %h got %h", $time, e.y_pos, data[31:24]);
                mismatches++;
            end
            if (data[47:32] !== e.glyph_color) begin
                $display("%0t: glyph_color expected %h got %h",
                         $time, e.glyph_color, data[47:32]);
                mismatches++;
            end
            if (data[48] !== e.large_font) begin
                $display("%0t: large_font expected %h got %h", $time, e.large_font, data[48]);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;

    draw_scoreboard sb = new();

    int idle_pct_in   = 0;
    int stall_pct_out = 0;
    int hold_cycles   = 0;
    int chars_sent    = 0;
    int cycle_count   = 0;

    string esc_set = "0123456789wrgbycmAaC/";
    string hex_set = "0123456789abcdefABCDEF";

    lcd_text_escape_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: check each accepted request, then pick next tready
    initial begin
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_request(m_axis_tdata, m_axis_tuser);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct_out);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic eos);
        while ($urandom_range(99) < idle_pct_in) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_char(c, eos);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input logic eos_last);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], eos_last && (i == s.len() - 1));
        end
    endtask

    function automatic logic rand_eos();
        return ($urandom_range(99) < 6);
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        return (c == CH_SLASH) ? (c ^ 8'h01) : c;
    endfunction

    // one token: plain char, escape pair, or hex color sequence
    task automatic send_token();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            send_char(rand_plain(), rand_eos());
        end else if (pick < 80) begin
            send_char(CH_SLASH, rand_eos());
            if (pick < 72) send_char(esc_set[$urandom_range(esc_set.len() - 1)], rand_eos());
            else send_char(8'($urandom_range(255)), rand_eos());
        end else begin
            send_char(CH_SLASH, rand_eos());
            send_char(CH_HASH, rand_eos());
            repeat (6) begin
                if ($urandom_range(9) == 0) send_char(8'($urandom_range(255)), rand_eos());
                else send_char(hex_set[$urandom_range(hex_set.len() - 1)], rand_eos());
            end
        end
    endtask

    task automatic run_phase(input int in_pct, input int out_pct, input int n);
        int target;
        idle_pct_in   = in_pct;
        stall_pct_out = out_pct;
        target = chars_sent + n;
        while (chars_sent < target) send_token();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("/9Q", 1'b0);
        send_text("/AX", 1'b0);
        send_text("/#FF8040", 1'b0);
        send_text("//", 1'b0);
        send_text("/q", 1'b0);
        send_text("/C", 1'b0);
        send_text("/#z", 1'b1);
        send_text("/", 1'b1);

        hold_cycles = 300;
        run_phase(0, 0, 90);

        send_text("/A", 1'b0);
        repeat (FONT_RUN) send_char(rand_plain(), 1'b0);
        send_text("/a", 1'b0);

        run_phase(63, 0, 90);
        run_phase(0, 63, 90);
        run_phase(18, 18, 90);

        s_axis_tvalid <= 1'b0;
        idle_pct_in   = 0;
        stall_pct_out = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d characters: plain text, every escape, hex colors, string ends",
                 chars_sent);
        $display("Checked %0d draw and %0d clear requests, with both fonts and back-pressure",
                 sb.draws_seen, sb.clears_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
